### src/mqtf_pkg.sv
`default_nettype none

package mqtf_pkg;

   // Default store depth, in filter bytes
   localparam int MAX_FILTER_LEN_DEF = 64;

   // Filter characters held in flops for the first beat of a topic
   localparam int HEAD_LEN = 5;
   // Characters seen around the cursor: one behind, the one at the cursor, four ahead
   localparam int WIN_LEN  = 6;
   // Window part kept in flops; the top two come from the memories
   localparam int WIN_REG  = 4;

   typedef logic [7:0] char_type;
   typedef logic [2:0] status_type;
   typedef char_type [WIN_LEN-1:0] win_type;

   // Commands
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_TOPIC  = 1'b1;

   // Characters with a meaning
   localparam char_type CH_NUL    = 8'h00;
   localparam char_type CH_HASH   = 8'h23;
   localparam char_type CH_DOLLAR = 8'h24;
   localparam char_type CH_PLUS   = 8'h2B;
   localparam char_type CH_SLASH  = 8'h2F;

   // Verdicts
   localparam status_type ST_NOMATCH      = 3'd0;
   localparam status_type ST_MATCH        = 3'd1;
   localparam status_type ST_EMPTY_FILTER = 3'd2;
   localparam status_type ST_EMPTY_TOPIC  = 3'd3;
   localparam status_type ST_TOPIC_WILD   = 3'd4;
   localparam status_type ST_BAD_PLUS     = 3'd5;
   localparam status_type ST_BAD_HASH     = 3'd6;

   // Match phases
   localparam int         PH_W     = 3;
   localparam logic [2:0] PH_FIRST = 3'd0;
   localparam logic [2:0] PH_RUN   = 3'd1;
   localparam logic [2:0] PH_PLUS  = 3'd2;
   localparam logic [2:0] PH_HASH  = 3'd3;
   localparam logic [2:0] PH_TAIL  = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;

   // Matcher context going into the evaluator
   typedef struct packed {
      logic [PH_W-1:0] phase;
      logic            after_eq;
      logic            bad_hash;
      logic            overflow;
      logic            len_zero;
      logic            pos_nz;
   } mctx_type;

   // Evaluator result for one topic beat
   typedef struct packed {
      logic [PH_W-1:0] phase;
      logic            after_eq;
      logic [1:0]      adv;
      logic            fixed;
      status_type      verdict;
   } mres_type;

endpackage

`default_nettype wire

### src/mqtf_req_if.sv
`default_nettype none

interface mqtf_req_if import mqtf_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     command;
   char_type char_in;
   logic     is_last;

   modport source (output valid, command, char_in, is_last, input ready);
   modport sink   (input valid, command, char_in, is_last, output ready);
endinterface

`default_nettype wire

### src/mqtf_rsp_if.sv
`default_nettype none

interface mqtf_rsp_if import mqtf_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

`default_nettype wire

### src/mqtf_ram.sv
`default_nettype none

module mqtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read (old data on a same-cycle collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/mqtf_eval.sv
`default_nettype none

module mqtf_eval import mqtf_pkg::*; (
   input  wire mctx_type ctx,
   input  wire win_type  win,
   input  wire char_type ch,
   input  wire logic     last,
   output mres_type      res
);

   // win[i] is the filter character at cursor + i - 1, zero past the end
   logic       wild_t;
   status_type nm;
   logic       run_go;
   logic       eot;
   logic       scan;
   logic       pns;
   logic       sp_nz;
   char_type   c;
   char_type   n;
   char_type   cm;
   char_type   c0;
   char_type   c1;
   char_type   c2;
   logic [2:0] i_m;
   logic [2:0] i_0;
   logic [2:0] i_1;
   logic [2:0] i_2;

   always_comb begin
      res.phase    = ctx.phase;
      res.after_eq = ctx.after_eq;
      res.adv      = 2'd0;
      res.fixed    = 1'b0;
      res.verdict  = ST_NOMATCH;
      wild_t = (ch == CH_PLUS) || (ch == CH_HASH);
      nm     = ctx.bad_hash ? ST_BAD_HASH : ST_NOMATCH;
      run_go = 1'b0;
      eot    = 1'b0;
      scan   = 1'b0;
      pns    = 1'b0;
      sp_nz  = 1'b0;
      c      = CH_NUL;
      n      = CH_NUL;
      cm     = CH_NUL;
      c0     = CH_NUL;
      c1     = CH_NUL;
      c2     = CH_NUL;
      i_m    = 3'd0;
      i_0    = 3'd0;
      i_1    = 3'd0;
      i_2    = 3'd0;

      // First beat checks, or dispatch by phase
      if (ctx.phase == PH_FIRST) begin
         priority if (ctx.overflow) begin
            res.fixed = 1'b1; res.verdict = ST_BAD_HASH;
         end else if (ctx.len_zero) begin
            res.fixed = 1'b1; res.verdict = ST_EMPTY_FILTER;
         end else if (ch == CH_NUL) begin
            res.fixed = 1'b1; res.verdict = ST_EMPTY_TOPIC;
         end else if ((win[1] == CH_DOLLAR) != (ch == CH_DOLLAR)) begin
            res.fixed = 1'b1; res.verdict = ST_NOMATCH;
         end else begin
            res.phase    = PH_RUN;
            res.after_eq = 1'b0;
            run_go       = 1'b1;
         end
      end else if (ctx.phase != PH_DONE) begin
         if (ch == CH_NUL) begin
            eot = 1'b1;
         end else begin
            unique case (ctx.phase)
               PH_RUN: begin
                  run_go = 1'b1;
               end
               PH_PLUS: begin
                  if (ch == CH_SLASH) begin
                     res.phase = PH_RUN;
                     run_go    = 1'b1;
                  end else if (wild_t) begin
                     res.fixed = 1'b1; res.verdict = ST_TOPIC_WILD;
                  end
               end
               PH_HASH, PH_TAIL: begin
                  if (wild_t) begin
                     res.fixed = 1'b1; res.verdict = ST_TOPIC_WILD;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // Compare against the filter; a '+' met by '/' takes a second step
      for (int k = 0; k < 2; k++) begin
         if (run_go && !res.fixed) begin
            run_go = 1'b0;
            c   = win[k+1];
            n   = win[k+2];
            pns = (k == 0) ? (ctx.pos_nz && (win[0] != CH_SLASH)) : (win[k] != CH_SLASH);
            if (wild_t) begin
               res.fixed = 1'b1; res.verdict = ST_TOPIC_WILD;
            end else if (c == CH_NUL) begin
               res.phase = PH_TAIL;
            end else if (c == ch) begin
               res.adv      = 2'(k + 1);
               res.after_eq = 1'b1;
            end else begin
               res.after_eq = 1'b0;
               if (c == CH_PLUS) begin
                  if (pns || ((n != CH_NUL) && (n != CH_SLASH))) begin
                     res.fixed = 1'b1; res.verdict = ST_BAD_PLUS;
                  end else begin
                     res.adv = 2'(k + 1);
                     if (ch == CH_SLASH) begin
                        run_go = 1'b1;
                     end else begin
                        res.phase = PH_PLUS;
                     end
                  end
               end else if (c == CH_HASH) begin
                  if (pns || (n != CH_NUL)) begin
                     res.fixed = 1'b1; res.verdict = ST_BAD_HASH;
                  end else begin
                     res.phase = PH_HASH;
                  end
               end else begin
                  res.fixed = 1'b1; res.verdict = nm;
               end
            end
         end
      end

      // Topic ended: settle against what is left of the filter
      if (!res.fixed && (ctx.phase != PH_DONE) && (eot || last)) begin
         i_m   = 3'(res.adv);
         i_0   = i_m + 3'd1;
         i_1   = i_m + 3'd2;
         i_2   = i_m + 3'd3;
         cm    = win[i_m];
         c0    = win[i_0];
         c1    = win[i_1];
         c2    = win[i_2];
         sp_nz = ctx.pos_nz || (res.adv != 2'd0);
         pns   = sp_nz && (cm != CH_SLASH);
         unique case (res.phase)
            PH_RUN: begin
               if (c0 == CH_NUL) begin
                  res.fixed = 1'b1; res.verdict = res.after_eq ? ST_MATCH : ST_NOMATCH;
               end else if (res.after_eq && (c0 == CH_SLASH) && (c1 == CH_HASH)
                            && (c2 == CH_NUL)) begin
                  res.fixed = 1'b1; res.verdict = ST_MATCH;
               end else begin
                  scan = 1'b1;
               end
            end
            PH_PLUS: begin
               if (c0 == CH_NUL) begin
                  res.fixed = 1'b1; res.verdict = ST_MATCH;
               end else begin
                  scan = 1'b1;
               end
            end
            PH_HASH: begin
               res.fixed = 1'b1; res.verdict = ST_MATCH;
            end
            PH_TAIL: begin
               res.fixed = 1'b1; res.verdict = ST_NOMATCH;
            end
            default: begin
            end
         endcase

         // Remaining filter after the topic: a lone trailing wildcard can still match
         if (scan) begin
            res.fixed = 1'b1;
            if (c0 == CH_PLUS) begin
               priority if (pns || ((c1 != CH_NUL) && (c1 != CH_SLASH))) begin
                  res.verdict = ST_BAD_PLUS;
               end else if (c1 == CH_NUL) begin
                  res.verdict = ST_MATCH;
               end else if (c2 == CH_HASH) begin
                  res.verdict = ST_MATCH;
               end else begin
                  res.verdict = nm;
               end
            end else if (c0 == CH_HASH) begin
               res.verdict = (pns || (c1 != CH_NUL)) ? ST_BAD_HASH : ST_MATCH;
            end else if (sp_nz && (cm == CH_PLUS) && (c0 == CH_SLASH) && (c1 == CH_HASH)) begin
               res.verdict = ST_MATCH;
            end else begin
               res.verdict = nm;
            end
         end
      end

      if (res.fixed) begin
         res.phase = PH_DONE;
      end
   end

endmodule

`default_nettype wire

### src/mqtt_topic_filter_match_core.sv
// The result beat is registered: it is valid in the cycle after the topic's last beat is accepted.
// Throughput: one beat (filter or topic) per cycle, held by the cursor loop from the
// filter cursor through the two memory read ports to the read data of the next cycle.
// A result waits in an output register; while the sink stalls it, request beats wait.
// Reset (synchronous) clears filter length, flags and match state; the filter
// memory is not cleared, so no clearing pass follows reset.
`default_nettype none

module mqtt_topic_filter_match_core import mqtf_pkg::*; #(
   parameter int MAX_FILTER_LEN = MAX_FILTER_LEN_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   mqtf_req_if.sink   req_chan,
   mqtf_rsp_if.source rsp_chan
);

   localparam int              LW    = $clog2(MAX_FILTER_LEN + 1);
   localparam int              XW    = $clog2(MAX_FILTER_LEN + 8);
   localparam int              AW    = $clog2(MAX_FILTER_LEN);
   localparam logic [LW-1:0]   MAX_L = LW'(MAX_FILTER_LEN);
   localparam logic [XW-1:0]   MAX_X = XW'(MAX_FILTER_LEN);

   logic req_acc;
   logic filt_acc;
   logic topic_acc;

   // Filter load state
   logic [LW-1:0] len_ff, len_in, len_new;
   logic          ovf_ff, ovf_in, ovf_new;
   logic          bhs_ff, bhs_in, bhs_new;
   logic          ended_ff, ended_in, ended_new;
   logic          busy_ff, busy_in;
   char_type      last_char_ff, last_char_in;
   char_type      head_ff [HEAD_LEN];
   char_type      head_in [HEAD_LEN];
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   // Match state
   logic [PH_W-1:0] phase_ff, phase_in;
   logic [LW-1:0]   pos_ff, pos_in, pos_eff;
   logic            ae_ff, ae_in;
   status_type      fixed_ff, fixed_in;
   char_type        win_ff [WIN_REG];
   char_type        win_in [WIN_REG];
   logic            first;
   win_type         raw;
   win_type         win_m;
   logic [XW-1:0]   pos_x;
   logic [2:0]      win_idx;
   mctx_type        ctx;
   mres_type        res;
   status_type      verdict;

   // Memory read side
   logic [XW-1:0] nxt_a, nxt_b;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   char_type      ram_a, ram_b;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;

   // Handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign filt_acc       = req_acc && (req_chan.command == CMD_FILTER);
   assign topic_acc      = req_acc && (req_chan.command == CMD_TOPIC);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;

   // Filter load: a beat after a finished filter starts a new one
   always_comb begin
      len_new      = busy_ff ? len_ff : '0;
      ovf_new      = busy_ff && ovf_ff;
      bhs_new      = busy_ff && bhs_ff;
      ended_new    = busy_ff && ended_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      bhs_in       = bhs_ff;
      ended_in     = ended_ff;
      busy_in      = busy_ff;
      last_char_in = last_char_ff;
      head_in      = head_ff;
      wr_en        = 1'b0;
      if (filt_acc) begin
         len_in   = len_new;
         ovf_in   = ovf_new;
         bhs_in   = bhs_new;
         ended_in = ended_new;
         busy_in  = !req_chan.is_last;
         if (!ended_new) begin
            if (req_chan.char_in == CH_NUL) begin
               ended_in = 1'b1;
            end else if (len_new >= MAX_L) begin
               ovf_in = 1'b1;
            end else begin
               // '#' followed by more characters
               if ((len_new != '0) && (last_char_ff == CH_HASH) && !bhs_new) begin
                  bhs_in = 1'b1;
               end
               wr_en        = 1'b1;
               last_char_in = req_chan.char_in;
               len_in       = len_new + LW'(1);
               for (int j = 0; j < HEAD_LEN; j++) begin
                  if (len_new == LW'(j)) begin
                     head_in[j] = req_chan.char_in;
                  end
               end
            end
         end
      end
   end

   assign wr_addr = len_new[AW-1:0];

   // Filter window around the cursor: head flops on the first beat,
   // otherwise window flops plus the two memory reads
   assign first   = (phase_ff == PH_FIRST);
   assign pos_eff = first ? '0 : pos_ff;

   always_comb begin
      raw[0] = first ? CH_NUL     : win_ff[0];
      raw[1] = first ? head_ff[0] : win_ff[1];
      raw[2] = first ? head_ff[1] : win_ff[2];
      raw[3] = first ? head_ff[2] : win_ff[3];
      raw[4] = first ? head_ff[3] : ram_a;
      raw[5] = first ? head_ff[4] : ram_b;
      pos_x  = '0;
      // Characters at or past the filter length read as zero
      for (int i = 0; i < WIN_LEN; i++) begin
         pos_x = XW'(pos_eff) + XW'(i);
         if ((pos_x <= XW'(len_ff)) && ((i != 0) || (pos_eff != '0))) begin
            win_m[i] = raw[i];
         end else begin
            win_m[i] = CH_NUL;
         end
      end
   end

   assign ctx.phase    = phase_ff;
   assign ctx.after_eq = ae_ff;
   assign ctx.bad_hash = bhs_ff;
   assign ctx.overflow = ovf_ff;
   assign ctx.len_zero = (len_ff == '0);
   assign ctx.pos_nz   = (pos_eff != '0);

   mqtf_eval u_eval (
      .ctx  (ctx),
      .win  (win_m),
      .ch   (req_chan.char_in),
      .last (req_chan.is_last),
      .res  (res)
   );

   assign verdict = res.fixed ? res.verdict : fixed_ff;

   // Match state update
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      ae_in    = ae_ff;
      fixed_in = fixed_ff;
      win_in   = win_ff;
      win_idx  = 3'd0;
      if (filt_acc) begin
         phase_in = PH_FIRST;
      end else if (topic_acc) begin
         phase_in = req_chan.is_last ? PH_FIRST : res.phase;
         ae_in    = res.after_eq;
         fixed_in = verdict;
         pos_in   = pos_eff + LW'(res.adv);
         for (int j = 0; j < WIN_REG; j++) begin
            win_idx   = 3'(res.adv) + 3'(j);
            win_in[j] = raw[win_idx];
         end
      end
   end

   // Prefetch the two characters beyond the next window flops
   always_comb begin
      nxt_a     = XW'(pos_in) + XW'(3);
      nxt_b     = XW'(pos_in) + XW'(4);
      rd_addr_a = (nxt_a < MAX_X) ? nxt_a[AW-1:0] : '0;
      rd_addr_b = (nxt_b < MAX_X) ? nxt_b[AW-1:0] : '0;
   end

   mqtf_ram #(
      .WIDTH ($bits(char_type)),
      .DEPTH (MAX_FILTER_LEN)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.char_in),
      .rd_addr (rd_addr_a),
      .rd_data (ram_a)
   );

   mqtf_ram #(
      .WIDTH ($bits(char_type)),
      .DEPTH (MAX_FILTER_LEN)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.char_in),
      .rd_addr (rd_addr_b),
      .rd_data (ram_b)
   );

   // Result beat goes out on the topic's last beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      if (topic_acc && req_chan.is_last) begin
         rsp_valid_in = 1'b1;
         status_in    = verdict;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         bhs_ff       <= 1'b0;
         ended_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         phase_ff     <= PH_FIRST;
         pos_ff       <= '0;
         ae_ff        <= 1'b0;
         fixed_ff     <= ST_NOMATCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         bhs_ff       <= bhs_in;
         ended_ff     <= ended_in;
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         ae_ff        <= ae_in;
         fixed_ff     <= fixed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      last_char_ff <= last_char_in;
      head_ff      <= head_in;
      win_ff       <= win_in;
      status_ff    <= status_in;
   end

   // A filter beat always restarts topic matching
   a_filter_restarts: assert property (@(posedge clock) disable iff (reset)
      filt_acc |=> (phase_ff == PH_FIRST))
      else $error("phase not restarted after filter beat");

   // Every last topic beat leaves a result waiting
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (topic_acc && req_chan.is_last) |=> rsp_valid_ff)
      else $error("no result after last topic beat");

   // Stored length never passes the store depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= MAX_L)
      else $error("filter length beyond store depth");

   // Cursor stays inside the stored filter while matching
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_RUN) || (phase_ff == PH_PLUS) || (phase_ff == PH_HASH)
       || (phase_ff == PH_TAIL)) |-> (pos_ff <= len_ff))
      else $error("filter cursor beyond filter length");

endmodule

`default_nettype wire
